@@ sv/tdor_pkg.sv @@
// Shared types and constants for the torus dimension-order route block.
package tdor_pkg;

	localparam int MAX_DIMS    = 3;
	localparam int MAX_PORTS   = 128;
	localparam int PACKED_DIMS = 3;
	localparam int NDIM        = (MAX_DIMS < PACKED_DIMS) ? MAX_DIMS : PACKED_DIMS;
	localparam int DIV_W       = 20;
	localparam int DIVR_W      = 8;
	localparam int CNT_W       = $clog2(DIV_W + 1);

	localparam logic [2:0] REG_NODE_ID     = 3'd0;
	localparam logic [2:0] REG_DIMS_IN_USE = 3'd1;
	localparam logic [2:0] REG_DIM_SIZES   = 3'd2;
	localparam logic [2:0] REG_DIM_WIDTHS  = 3'd3;
	localparam logic [2:0] REG_HOST_PORTS  = 3'd4;

	typedef struct packed {
		logic [19:0] dest_id;
		logic [6:0]  in_port;
		logic [3:0]  in_vc;
		logic [1:0]  cur_dim;
	} item_t;

	typedef struct packed {
		logic [6:0] out_port;
		logic [3:0] out_vc;
		logic [1:0] out_routing_dim;
		logic       to_local;
		logic       route_error;
	} res_t;

	// effective configuration, zero dims, sizes, widths and host ports already mapped to one
	typedef struct packed {
		logic [15:0]           node_id;
		logic [1:0]            ndims;
		logic [NDIM-1:0][7:0]  sizes;
		logic [NDIM-1:0][3:0]  widths;
		logic [4:0]            lports;
		logic [6:0]            local_start;
	} cfg_t;

endpackage

@@ sv/tdor_front.sv @@
// Input side: accepts headers, splits the fields and queues them for the back end.
module tdor_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [39:0]         s_tdata,
	output logic                q_valid,
	input  logic                q_pop,
	output tdor_pkg::item_t     q_item
);

	tdor_pkg::item_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	tdor_pkg::item_t in_item;
	logic            push;
	logic            pop;

	always_comb begin
		in_item.dest_id = s_tdata[19:0];
		in_item.in_port = s_tdata[26:20];
		in_item.in_vc   = s_tdata[30:27];
		in_item.cur_dim = s_tdata[32:31];
	end

	assign s_tready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign push     = s_tvalid && s_tready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk) begin
		q_item <= pop ? mem_q[~rd_ptr_q] : mem_q[rd_ptr_q];
		if (push && ((count_q == 2'd0) || (pop && count_q == 2'd1))) begin
			q_item <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ sv/tdor_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module tdor_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tdor_pkg::DIV_W-1:0]    dividend,
	input  logic [tdor_pkg::DIVR_W-1:0]   divisor,
	output logic                          done,
	output logic [tdor_pkg::DIV_W-1:0]    quotient,
	output logic [tdor_pkg::DIVR_W-1:0]   remainder
);

	logic [tdor_pkg::DIV_W-1:0]  quo_q;
	logic [tdor_pkg::DIVR_W-1:0] rem_q;
	logic [tdor_pkg::DIVR_W-1:0] dvs_q;
	logic [tdor_pkg::CNT_W-1:0]  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [tdor_pkg::DIVR_W:0]   trial;
	logic                        fits;

	assign trial = {rem_q, quo_q[tdor_pkg::DIV_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[tdor_pkg::DIV_W-2:0], fits};
			rem_q <= fits ? tdor_pkg::DIVR_W'(trial - {1'b0, dvs_q})
				: trial[tdor_pkg::DIVR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == tdor_pkg::CNT_W'(tdor_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

@@ sv/tdor_back.sv @@
// Route sequencer: destination split, coordinate extraction, port and VC choice.
module tdor_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tdor_pkg::cfg_t      cfg,
	input  logic                q_valid,
	output logic                q_pop,
	input  tdor_pkg::item_t     q_item,
	output logic                res_valid,
	input  logic                res_ready,
	output tdor_pkg::res_t      res
);

	typedef enum logic [2:0] {S_IDLE, S_DLP, S_CRD, S_SEL, S_DW, S_OUT} state_t;

	state_t                            state_q;
	tdor_pkg::item_t                   item_q;
	tdor_pkg::res_t                    res_q;
	logic [19:0]                       qdest_q;
	logic [1:0]                        idx_q;
	logic                              side_q;
	logic [tdor_pkg::NDIM-1:0][7:0]    my_q;
	logic [tdor_pkg::NDIM-1:0][7:0]    dst_q;
	logic [7:0]                        base_q;

	logic                              div_start;
	logic [19:0]                       div_dividend;
	logic [7:0]                        div_divisor;
	logic                              div_done;
	logic [19:0]                       div_quo;
	logic [7:0]                        div_rem;

	tdor_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// dimension choice over the stored coordinates
	logic       found;
	logic [1:0] sel;
	logic [7:0] sz;
	logic [7:0] myc;
	logic [7:0] dsc;
	logic [8:0] spos;
	logic [8:0] sneg;
	logic [7:0] dpos;
	logic [7:0] dneg;
	logic       go_pos;
	logic [7:0] base;
	logic [3:0] vc_sel;
	logic [3:0] vc_miss;

	always_comb begin
		found = 1'b0;
		sel   = 2'd0;
		base  = 8'd0;
		for (int d = 0; d < tdor_pkg::NDIM; d++) begin
			if (!found && (2'(d) >= item_q.cur_dim) && (2'(d) < cfg.ndims)
				&& (dst_q[d] != my_q[d])) begin
				found = 1'b1;
				sel   = 2'(d);
			end
		end
		for (int d = 0; d < tdor_pkg::NDIM; d++) begin
			if (2'(d) < sel) begin
				base = base + {3'd0, cfg.widths[d], 1'b0};
			end
		end
		sz   = cfg.sizes[sel];
		myc  = my_q[sel];
		dsc  = dst_q[sel];
		spos = {1'b0, dsc} + {1'b0, sz} - {1'b0, myc};
		sneg = {1'b0, myc} + {1'b0, sz} - {1'b0, dsc};
		dpos = (spos >= {1'b0, sz}) ? 8'(spos - {1'b0, sz}) : spos[7:0];
		dneg = (sneg >= {1'b0, sz}) ? 8'(sneg - {1'b0, sz}) : sneg[7:0];
		go_pos = (dpos <= dneg);
		if (!go_pos) begin
			base = base + {4'd0, cfg.widths[sel]};
		end
		vc_sel = (sel > item_q.cur_dim) ? {item_q.in_vc[3:1], 1'b0} : item_q.in_vc;
		if ((myc == 8'd0) && (item_q.in_port < cfg.local_start)) begin
			vc_sel[0] = ~vc_sel[0];
		end
		vc_miss = (item_q.cur_dim < cfg.ndims) ? {item_q.in_vc[3:1], 1'b0}
			: item_q.in_vc;
	end

	logic [8:0] route_port;
	logic [7:0] local_port;
	assign route_port = {1'b0, base_q} + {1'b0, div_rem};
	assign local_port = {1'b0, cfg.local_start} + {3'd0, div_rem[4:0]};

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign res_valid = (state_q == S_OUT);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			div_start    <= 1'b0;
			div_dividend <= '0;
			div_divisor  <= '0;
			idx_q        <= '0;
			side_q       <= 1'b0;
			item_q       <= '0;
			res_q        <= '0;
			qdest_q      <= '0;
			my_q         <= '0;
			dst_q        <= '0;
			base_q       <= '0;
		end else begin
			div_start <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						item_q       <= q_item;
						div_dividend <= q_item.dest_id;
						div_divisor  <= {3'd0, cfg.lports};
						div_start    <= 1'b1;
						state_q      <= S_DLP;
					end
				end
				S_DLP: begin
					if (div_done) begin
						qdest_q <= div_quo;
						if (div_quo == {4'd0, cfg.node_id}) begin
							res_q.out_port        <= local_port[6:0];
							res_q.out_vc          <= item_q.in_vc;
							res_q.out_routing_dim <= item_q.cur_dim;
							res_q.to_local        <= 1'b1;
							res_q.route_error     <= 1'b0;
							state_q               <= S_OUT;
						end else begin
							idx_q        <= 2'd0;
							side_q       <= 1'b0;
							div_dividend <= {4'd0, cfg.node_id};
							div_divisor  <= cfg.sizes[0];
							div_start    <= 1'b1;
							state_q      <= S_CRD;
						end
					end
				end
				S_CRD: begin
					if (div_done) begin
						if (side_q) begin
							dst_q[idx_q] <= div_rem;
						end else begin
							my_q[idx_q] <= div_rem;
						end
						if (idx_q + 2'd1 < cfg.ndims) begin
							idx_q        <= idx_q + 2'd1;
							div_dividend <= div_quo;
							div_divisor  <= cfg.sizes[idx_q + 2'd1];
							div_start    <= 1'b1;
						end else if (!side_q) begin
							idx_q        <= 2'd0;
							side_q       <= 1'b1;
							div_dividend <= qdest_q;
							div_divisor  <= cfg.sizes[0];
							div_start    <= 1'b1;
						end else begin
							state_q <= S_SEL;
						end
					end
				end
				S_SEL: begin
					if (found) begin
						base_q                <= base;
						res_q.out_vc          <= vc_sel;
						res_q.out_routing_dim <= sel;
						div_dividend          <= {12'd0, go_pos ? dpos : dneg};
						div_divisor           <= {4'd0, cfg.widths[sel]};
						div_start             <= 1'b1;
						state_q               <= S_DW;
					end else begin
						res_q.out_port        <= 7'd0;
						res_q.out_vc          <= vc_miss;
						res_q.out_routing_dim <= (item_q.cur_dim < cfg.ndims) ? cfg.ndims
							: item_q.cur_dim;
						res_q.to_local        <= 1'b0;
						res_q.route_error     <= 1'b1;
						state_q               <= S_OUT;
					end
				end
				S_DW: begin
					if (div_done) begin
						res_q.to_local <= 1'b0;
						if (route_port >= 9'(tdor_pkg::MAX_PORTS)) begin
							res_q.out_port    <= 7'd0;
							res_q.route_error <= 1'b1;
						end else begin
							res_q.out_port    <= route_port[6:0];
							res_q.route_error <= 1'b0;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ sv/torus_dimension_order_route.sv @@
// Torus dimension-order route computation with dateline VC selection.
// Usage:
//   s_* channel takes one packet header per item (destination, arrival port,
//   arrival VC, current dimension); m_* channel returns one result item per header.
//   cfg_* writes a register (0 node id, 1 dims in use, 2 ring sizes,
//   3 link counts, 4 host ports per router); other indexes are dropped.
//   cfg_ready is always high. Write only while no header is in flight.
// Sequencing: one shared serial divider does every split. A header first has
//   its destination divided by the host port count; a quotient equal to the
//   node id gives a local delivery. Otherwise the node id and then the router
//   part of the destination are split into one coordinate per dim in use, and
//   a differing dimension is chosen (none gives a route error); a network route
//   takes a last division of the ring distance by the link count. One header is
//   worked on at a time; the next is taken only after the result is accepted.
// A two-entry queue in front takes new headers while the back end works or
//   while a result waits on a stalled m_tready; s_tready drops when it is
//   full, and the result is held stable until taken.
// Reset empties the queue, idles the sequencer and loads the registers
//   with their defaults (3 dims, rings of 4, one link, one host port).
module torus_dimension_order_route (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // dest_id[19:0], in_port[26:20], in_vc[30:27], cur_dim[32:31]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_port[6:0], out_vc[10:7], out_routing_dim[12:11]
	output logic [1:0]  m_tuser,   // to_local[0], route_error[1]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	logic [15:0] node_id_q;
	logic [1:0]  dims_q;
	logic [23:0] sizes_q;
	logic [11:0] widths_q;
	logic [4:0]  lports_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= 16'd0;
			dims_q    <= 2'd3;
			sizes_q   <= 24'h040404;
			widths_q  <= 12'h111;
			lports_q  <= 5'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tdor_pkg::REG_NODE_ID:     node_id_q <= cfg_data[15:0];
				tdor_pkg::REG_DIMS_IN_USE: dims_q    <= cfg_data[1:0];
				tdor_pkg::REG_DIM_SIZES:   sizes_q   <= cfg_data;
				tdor_pkg::REG_DIM_WIDTHS:  widths_q  <= cfg_data[11:0];
				tdor_pkg::REG_HOST_PORTS:  lports_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	tdor_pkg::cfg_t cfg;

	always_comb begin
		cfg.node_id = node_id_q;
		cfg.ndims   = (dims_q == 2'd0) ? 2'd1 : dims_q;
		if (cfg.ndims > 2'(tdor_pkg::NDIM)) begin
			cfg.ndims = 2'(tdor_pkg::NDIM);
		end
		cfg.lports      = (lports_q == 5'd0) ? 5'd1 : lports_q;
		cfg.local_start = 7'd0;
		for (int d = 0; d < tdor_pkg::NDIM; d++) begin
			cfg.sizes[d]  = (sizes_q[8*d +: 8] == 8'd0) ? 8'd1 : sizes_q[8*d +: 8];
			cfg.widths[d] = (widths_q[4*d +: 4] == 4'd0) ? 4'd1 : widths_q[4*d +: 4];
			if (2'(d) < cfg.ndims) begin
				cfg.local_start = cfg.local_start + {2'd0, cfg.widths[d], 1'b0};
			end
		end
	end

	logic            q_valid;
	logic            q_pop;
	tdor_pkg::item_t q_item;
	tdor_pkg::res_t  res;

	tdor_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	tdor_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {3'd0, res.out_routing_dim, res.out_vc, res.out_port};
	assign m_tuser = {res.route_error, res.to_local};

endmodule

@@ sv/tdor_checker.sv @@
// Port-level checks for the route block, bound to the top level.
module tdor_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_err_port: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata[6:0] == 7'd0) && !m_tuser[0])
		else $error("error result with port or local flag set");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:13] == 3'd0))
		else $error("result padding not zero");

endmodule

bind torus_dimension_order_route tdor_checker u_tdor_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
